[sv/pdpq_pkg.sv]
// ----------------------------------------------------------------------------
// Packet delay priority queue package
// Shared widths, codes, item formats and control structs for the delay queue.
// ----------------------------------------------------------------------------
package pdpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int DELAY_ENTRIES   = 4;
    localparam int NUM_DELAY_REGS  = 4;
    localparam int MAX_RESULTS     = 32;
    localparam int RES_W           = $clog2(MAX_RESULTS + 1);

    localparam int TIME_W    = 48;
    localparam int HANDLE_W  = 16;
    localparam int DELAY_W   = 24;
    localparam int COUNT_W   = 3;
    localparam int DIDX_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_THREE = 3'd4;

    typedef enum logic [1:0] {
        ACT_ARRIVE = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_PASS    = 2'd0,
        KIND_DROP    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_TIMER   = 2'd3
    } kind_t;

    typedef struct packed {
        action_t             action;
        logic [HANDLE_W-1:0] packet_handle;
        logic                is_new;
        logic                filter_pass;
        logic [TIME_W-1:0]   now_time;
    } in_item_t;

    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] out_handle;
        logic [TIME_W-1:0]   wake_time;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0]   send_time;
        logic [HANDLE_W-1:0] handle;
        logic                asked;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic pop;
        logic mark;
    } chain_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_INSERT = 2'd1,
        ST_DRAIN  = 2'd2
    } state_t;

endpackage

[sv/pdpq_cell.sv]
// ----------------------------------------------------------------------------
// Delay queue cell
// One slot of the sorted queue; shifts toward the head on a pop and away from
// it behind the insertion point on an insert.
// ----------------------------------------------------------------------------
module pdpq_cell (
    input  logic                aclk,
    input  pdpq_pkg::chain_cmd_t cmd,
    input  logic                cell_valid,
    input  pdpq_pkg::entry_t    new_entry,
    input  pdpq_pkg::entry_t    prev_entry,
    input  logic                prev_keep,
    input  pdpq_pkg::entry_t    next_entry,
    output pdpq_pkg::entry_t    entry,
    output logic                keep
);
    import pdpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An occupied slot whose send time is not later than the new one stays;
    // ties keep arrival order.
    assign keep = cell_valid && (entry_reg.send_time <= new_entry.send_time);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.pop) begin
            entry_next = next_entry;
        end else if (cmd.insert) begin
            if (!keep) begin
                entry_next = prev_keep ? new_entry : prev_entry;
            end
        end else if (cmd.mark) begin
            entry_next.asked = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[sv/pdpq_chain.sv]
// ----------------------------------------------------------------------------
// Delay queue cell chain
// A row of cells kept in send-time order, head at cell zero, with the fill
// count that marks which cells hold entries.
// ----------------------------------------------------------------------------
module pdpq_chain #(
    parameter int DEPTH = pdpq_pkg::QUEUE_DEPTH_DEF,
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pdpq_pkg::chain_cmd_t cmd,
    input  pdpq_pkg::entry_t     new_entry,
    output logic [OCC_W-1:0]     occupancy,
    output pdpq_pkg::entry_t     head,
    output pdpq_pkg::entry_t     second
);
    import pdpq_pkg::*;

    entry_t           entries [DEPTH];
    logic [DEPTH-1:0] keep;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t     prev_entry;
        entry_t     next_entry;
        logic       prev_keep;
        chain_cmd_t cell_cmd;

        if (i == 0) begin : g_first
            assign prev_entry = entries[i];
            assign prev_keep  = 1'b1;
        end else begin : g_inner
            assign prev_entry = entries[i-1];
            assign prev_keep  = keep[i-1];
        end

        if (i == DEPTH - 1) begin : g_end
            assign next_entry = entries[i];
        end else begin : g_mid
            assign next_entry = entries[i+1];
        end

        // Only the head ever receives a timer mark.
        assign cell_cmd.insert = cmd.insert;
        assign cell_cmd.pop    = cmd.pop;
        assign cell_cmd.mark   = (i == 0) ? cmd.mark : 1'b0;

        pdpq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .cell_valid (occ_reg > OCC_W'(i)),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .prev_keep  (prev_keep),
            .next_entry (next_entry),
            .entry      (entries[i]),
            .keep       (keep[i])
        );
    end

    if (DEPTH > 1) begin : g_second
        assign second = entries[1];
    end else begin : g_no_second
        assign second = '0;
    end

    assign head = entries[0];

    always_comb begin
        occ_next = occ_reg;
        if (cmd.insert) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (cmd.pop) begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign occupancy = occ_reg;

endmodule

[sv/packet_delay_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Packet delay priority queue unit
// A network-emulator delay stage. An arriving packet item that is new and has
// passed the filters takes the next delay of a cyclic table of up to four
// entries and is held until its arrival time plus that delay; packets that
// are not new, are filtered out or draw a zero delay pass straight through,
// and a delayable packet meets a full queue is dropped. A tick item releases
// every due entry, earliest send time first (ties in arrival order), and when
// the head is not yet due it asks once per entry for a timer at the head's
// send time. A flush item releases everything in send-time order. A tick or
// flush gives at most 32 results, the final one flagged by last. An arrival
// that passes or is dropped returns its result through the output register;
// an arrival that is queued has its saturated send time registered on
// acceptance and is inserted in the insert state, in which every cell of
// the chain compares its send time against the new one in parallel and the
// cells behind the insertion point shift by one. A tick or flush is
// accepted and then drains one result per cycle while the output is not
// stalled, since the head leaves the chain by a one-place shift and the
// single output register holds one result; a tick or flush that gives no
// result, because the queue is empty or the head is not due and already
// has its timer request, still passes through the drain state. A stalled
// output pauses the drain. The queue needs no clearing after reset: the fill
// count alone says which cells are live.
// ----------------------------------------------------------------------------
module packet_delay_priority_queue_unit #(
    parameter int QUEUE_DEPTH = pdpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [pdpq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pdpq_pkg::CFG_W-1:0]        cfg_data,
    // Input item channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pdpq_pkg::in_item_t                s_data,
    // Result item channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output pdpq_pkg::out_item_t               m_data
);
    import pdpq_pkg::*;

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers.
    logic [COUNT_W-1:0] delay_count_reg;
    logic [DELAY_W-1:0] delay_table_reg [NUM_DELAY_REGS];

    // Control state.
    state_t             state_reg;
    state_t             state_next;
    logic [DIDX_W-1:0]  delay_index_reg;
    logic [DIDX_W-1:0]  delay_index_next;
    logic [RES_W-1:0]   res_cnt_reg;
    logic               m_valid_reg;

    // Item payload held between cycles.
    entry_t             ins_entry_reg;
    logic [TIME_W-1:0]  drain_now_reg;
    logic               drain_flush_reg;
    out_item_t          m_data_reg;

    // Chain interface.
    chain_cmd_t         cmd;
    logic [OCC_W-1:0]   occupancy;
    entry_t             head;
    entry_t             second;

    // Decisions.
    logic               out_free;
    logic               accept;
    logic               delayable;
    logic               q_full;
    logic               q_empty;
    logic               queue_it;
    logic [DELAY_W-1:0] cur_delay;
    logic [TIME_W:0]    send_sum;
    logic [TIME_W-1:0]  send_sat;
    logic [COUNT_W-1:0] eff_count;
    logic [COUNT_W-1:0] idx_inc;
    logic               head_late;
    logic               rel_last;
    logic               out_load;
    out_item_t          out_next;
    logic               idx_adv;

    // ------------------------------------------------------------------
    // Cell chain holding the queued entries in send-time order.
    // ------------------------------------------------------------------
    pdpq_chain #(
        .DEPTH (QUEUE_DEPTH),
        .OCC_W (OCC_W)
    ) u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .new_entry (ins_entry_reg),
        .occupancy (occupancy),
        .head      (head),
        .second    (second)
    );

    // ------------------------------------------------------------------
    // Configuration writes. Indexes beyond the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_count_reg <= COUNT_W'(1);
            for (int i = 0; i < NUM_DELAY_REGS; i++) begin
                delay_table_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DELAY_COUNT: delay_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_DELAY_ZERO:  delay_table_reg[0] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_ONE:   delay_table_reg[1] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_TWO:   delay_table_reg[2] <= cfg_data[DELAY_W-1:0];
                REG_DELAY_THREE: delay_table_reg[3] <= cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared decision logic.
    // ------------------------------------------------------------------
    // The output register is free when it is empty or being emptied now.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // Arrival path: only new packets that passed the filters are delayed.
    assign delayable = s_data.is_new && s_data.filter_pass;
    assign q_full    = occupancy >= OCC_W'(QUEUE_DEPTH);
    assign q_empty   = occupancy == '0;
    assign cur_delay = delay_table_reg[delay_index_reg];
    assign queue_it  = delayable && !q_full && (cur_delay != '0);

    // The send time saturates at the largest representable time.
    assign send_sum = {1'b0, s_data.now_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, cur_delay};
    assign send_sat = send_sum[TIME_W] ? TIME_MAX : send_sum[TIME_W-1:0];

    // A table length of zero behaves as one, and one above the table size
    // behaves as the table size. An index left beyond a shortened length is
    // still used once and then wraps.
    assign eff_count = (delay_count_reg == '0) ? COUNT_W'(1) :
                       (delay_count_reg > COUNT_W'(DELAY_ENTRIES)) ?
                       COUNT_W'(DELAY_ENTRIES) : delay_count_reg;
    assign idx_inc   = COUNT_W'(delay_index_reg) + COUNT_W'(1);
    assign delay_index_next = (idx_inc >= eff_count) ? '0 : idx_inc[DIDX_W-1:0];

    // Drain path. On a tick the head is late when it is not yet due. A
    // release is the final result when the queue empties, when the result
    // limit is reached, or when the next head is not due and has already
    // had its timer request.
    assign head_late = !drain_flush_reg && (head.send_time > drain_now_reg);
    assign rel_last  = (occupancy == OCC_W'(1)) ||
                       (res_cnt_reg == RES_W'(MAX_RESULTS - 1)) ||
                       (!drain_flush_reg && (second.send_time > drain_now_reg) &&
                        second.asked);

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.action)
                        ACT_ARRIVE: state_next = queue_it ? ST_INSERT : ST_IDLE;
                        ACT_TICK:   state_next = ST_DRAIN;
                        ACT_FLUSH:  state_next = ST_DRAIN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: begin
                state_next = ST_IDLE;
            end
            ST_DRAIN: begin
                if (out_free) begin
                    if (q_empty || head_late || rel_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the state machine: result loads and chain commands.
    // ------------------------------------------------------------------
    always_comb begin
        out_load = 1'b0;
        out_next = '0;
        cmd      = '0;
        idx_adv  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.action == ACT_ARRIVE)) begin
                    // The table index moves on only for a new, filtered-in packet that is not dropped.
                    idx_adv = delayable && !q_full;
                    if (!queue_it) begin
                        out_load            = 1'b1;
                        out_next.kind       = (delayable && q_full) ? KIND_DROP : KIND_PASS;
                        out_next.out_handle = s_data.packet_handle;
                        out_next.last       = 1'b1;
                    end
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
            end
            ST_DRAIN: begin
                if (out_free && !q_empty) begin
                    if (head_late) begin
                        if (!head.asked) begin
                            out_load           = 1'b1;
                            out_next.kind      = KIND_TIMER;
                            out_next.wake_time = head.send_time;
                            out_next.last      = 1'b1;
                            cmd.mark           = 1'b1;
                        end
                    end else begin
                        out_load            = 1'b1;
                        out_next.kind       = KIND_RELEASE;
                        out_next.out_handle = head.handle;
                        out_next.last       = rel_last;
                        cmd.pop             = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            delay_index_reg <= '0;
            res_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (idx_adv) begin
                delay_index_reg <= delay_index_next;
            end
            if (accept) begin
                res_cnt_reg <= '0;
            end else if (cmd.pop) begin
                res_cnt_reg <= res_cnt_reg + RES_W'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            ins_entry_reg.send_time <= send_sat;
            ins_entry_reg.handle    <= s_data.packet_handle;
            ins_entry_reg.asked     <= 1'b0;
            drain_now_reg           <= s_data.now_time;
            drain_flush_reg         <= (s_data.action == ACT_FLUSH);
        end
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A queued packet never finds the chain full; the drop check guards it.
    a_insert_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> (occupancy < OCC_W'(QUEUE_DEPTH)))
        else $error("insert issued into a full queue");

    // A release is only ever taken from an occupied chain.
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (occupancy != '0))
        else $error("pop issued on an empty queue");

    // A timer request always ends the drain.
    a_timer_ends_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (out_next.kind == KIND_TIMER)) |=> (state_reg == ST_IDLE))
        else $error("drain continued after a timer request");

    // The chain stays in send-time order at its head.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (occupancy > OCC_W'(1)) |-> (head.send_time <= second.send_time))
        else $error("queue head is later than its successor");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet delay priority queue testbench
// Drives arrival, tick and flush items into the delay queue and predicts every
// pass, drop, release and timer result. The prediction keeps its own copy of
// the delay table and of the held packets. Directed items come first, then
// random item streams under several register settings and idling patterns.
// One stretch holds the result side off so that the queue fills up and the
// input stalls.
// ----------------------------------------------------------------------------
module tb;
    import pdpq_pkg::*;

    // Action code 3 is not a member of action_t; the block must ignore it.
    localparam action_t ACT_UNKNOWN = action_t'(2'd3);

    localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
    localparam int HOLD_CYCLES  = 300;   // long result-side hold-off
    localparam int SETTLE       = 8;     // cycles for an item without results
    localparam int END_SETTLE   = 64;    // final wait for stray results
    localparam int STALL_LIMIT  = 4000;  // cycles without any handshake
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // Prediction and checking. The tracker holds the delay table and the held
    // packets in arrival order, works out the results of every accepted item
    // and compares each result that leaves the block with the oldest one.
    // ------------------------------------------------------------------------
    class delay_queue_tracker;
        out_item_t          awaited_results[$];
        entry_t             held[$];
        logic [COUNT_W-1:0] delay_count;
        logic [DELAY_W-1:0] delay_table[DELAY_ENTRIES];
        logic [DIDX_W-1:0]  delay_index;
        int                 error_count;

        function new();
            delay_count = 3'd1;
            foreach (delay_table[k]) delay_table[k] = '0;
            delay_index = '0;
            error_count = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
            case (idx)
                REG_DELAY_COUNT: delay_count    = value[COUNT_W-1:0];
                REG_DELAY_ZERO:  delay_table[0] = value[DELAY_W-1:0];
                REG_DELAY_ONE:   delay_table[1] = value[DELAY_W-1:0];
                REG_DELAY_TWO:   delay_table[2] = value[DELAY_W-1:0];
                REG_DELAY_THREE: delay_table[3] = value[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_result(input kind_t kind, input logic [HANDLE_W-1:0] handle,
                                 input logic [TIME_W-1:0] wake);
            out_item_t r;
            r.kind       = kind;
            r.out_handle = handle;
            r.wake_time  = wake;
            r.last       = 1'b0;
            awaited_results.push_back(r);
        endfunction

        // Earliest send time; on equal times the packet that arrived first.
        function int earliest_held();
            int best;
            best = 0;
            for (int i = 1; i < held.size(); i++)
                if (held[i].send_time < held[best].send_time) best = i;
            return best;
        endfunction

        function void note_item(input in_item_t it);
            int                 first;
            int                 used;
            int                 p;
            logic [DELAY_W-1:0] d;
            logic [TIME_W:0]    sum;
            entry_t             e;
            first = awaited_results.size();
            case (it.action)
                ACT_ARRIVE: begin
                    if (!it.is_new || !it.filter_pass) begin
                        add_result(KIND_PASS, it.packet_handle, '0);
                    end else if (held.size() >= QUEUE_DEPTH) begin
                        // A dropped packet leaves the table index where it is.
                        add_result(KIND_DROP, it.packet_handle, '0);
                    end else begin
                        used = int'(delay_count);
                        if (used < 1) used = 1;
                        if (used > DELAY_ENTRIES) used = DELAY_ENTRIES;
                        // An index left beyond a reduced count is used once
                        // more and then wraps to zero.
                        d = delay_table[delay_index];
                        if (int'(delay_index) + 1 >= used) delay_index = '0;
                        else delay_index = delay_index + 1'b1;
                        if (d == '0) begin
                            add_result(KIND_PASS, it.packet_handle, '0);
                        end else begin
                            // A queued packet gives no result of its own.
                            sum = {1'b0, it.now_time} + (TIME_W + 1)'(d);
                            e.send_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                            e.handle    = it.packet_handle;
                            e.asked     = 1'b0;
                            held.push_back(e);
                        end
                    end
                end
                ACT_TICK: begin
                    while (held.size() > 0 && awaited_results.size() - first < MAX_RESULTS)
                    begin
                        p = earliest_held();
                        if (held[p].send_time > it.now_time) begin
                            if (!held[p].asked) begin
                                add_result(KIND_TIMER, '0, held[p].send_time);
                                held[p].asked = 1'b1;
                            end
                            break;
                        end
                        add_result(KIND_RELEASE, held[p].handle, '0);
                        held.delete(p);
                    end
                end
                ACT_FLUSH: begin
                    while (held.size() > 0 && awaited_results.size() - first < MAX_RESULTS)
                    begin
                        p = earliest_held();
                        add_result(KIND_RELEASE, held[p].handle, '0);
                        held.delete(p);
                    end
                end
                default: ;
            endcase
            if (awaited_results.size() > first)
                awaited_results[awaited_results.size() - 1].last = 1'b1;
        endfunction

        function void check_result(input out_item_t got);
            out_item_t want;
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result: kind %0d handle %h wake %h last %b",
                             got.kind, got.out_handle, got.wake_time, got.last);
                return;
            end
            want = awaited_results.pop_front();
            if (got.kind !== want.kind || got.out_handle !== want.out_handle ||
                got.wake_time !== want.wake_time || got.last !== want.last) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("result mismatch: expected kind %0d handle %h wake %h last %b, %s",
                             want.kind, want.out_handle, want.wake_time, want.last,
                             $sformatf("got kind %0d handle %h wake %h last %b",
                                       got.kind, got.out_handle, got.wake_time, got.last));
            end
        endfunction

        function void finish_check();
            if (awaited_results.size() != 0) begin
                error_count += awaited_results.size();
                $display("%0d expected results never arrived", awaited_results.size());
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals and instance.
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    packet_delay_priority_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    delay_queue_tracker tracker;

    // Idling odds in percent, changed by phase; the hold request starts the
    // long result-side stall, which the receiver counts out by itself.
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_request;
    int          quiet_cycles;
    logic [TIME_W-1:0] sim_now;

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side. The ready is driven at the falling edge, and a result is
    // checked at the rising edge where valid and ready are both high.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            tracker.check_result(m_data);
    end

    // The run is stuck if no item moves on either side for a long time.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Inputs change at the falling edge only.
    // ------------------------------------------------------------------------
    function automatic in_item_t make_item(input action_t act,
                                           input logic [HANDLE_W-1:0] handle,
                                           input logic fresh, input logic passed,
                                           input logic [TIME_W-1:0] now);
        in_item_t it;
        it.action        = act;
        it.packet_handle = handle;
        it.is_new        = fresh;
        it.filter_pass   = passed;
        it.now_time      = now;
        return it;
    endfunction

    // Offers one item after a random gap and returns once it is accepted.
    // Valid stays high from one item to the next unless a gap comes between.
    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_data  = item;
        s_valid = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_item(item);
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Stops input and waits until the block is idle, so that registers may
    // be written. Items without results may still be at work, hence the
    // extra cycles.
    task automatic quiesce();
        idle_input();
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.write_reg(idx, value);
    endtask

    // Delays lean toward small values so that ticks release packets a few
    // at a time; zero and the largest delay show up now and then.
    function automatic logic [CFG_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return {DELAY_W{1'b1}};
        if (r < 35) return CFG_W'($urandom_range(0, 24'hFFFFFF));
        return CFG_W'($urandom_range(1, 300));
    endfunction

    task automatic configure(input logic [CFG_W-1:0] count);
        quiesce();
        write_reg(REG_DELAY_COUNT, count);
        for (int k = 0; k < NUM_DELAY_REGS; k++)
            write_reg(REG_DELAY_ZERO + CFG_IDX_W'(k), pick_delay());
    endtask

    // Mostly well-formed traffic: arrivals and ticks at a steadily advancing
    // time, some flushes, and about one item in ten of pure noise with any
    // action code and any time.
    function automatic in_item_t random_item();
        in_item_t    it;
        logic [63:0] wide;
        int          pick;
        pick = $urandom_range(0, 99);
        wide = {$urandom(), $urandom()};
        it = make_item(ACT_ARRIVE, HANDLE_W'($urandom_range(0, 65535)), 1'b1, 1'b1, sim_now);
        if (pick < 55) begin
            if ($urandom_range(0, 9) == 0) begin
                it.is_new      = 1'($urandom_range(0, 1));
                it.filter_pass = 1'($urandom_range(0, 1));
            end
            sim_now = sim_now + TIME_W'($urandom_range(0, 20));
        end else if (pick < 85) begin
            it.action = ACT_TICK;
            sim_now = sim_now + TIME_W'($urandom_range(0, 120));
        end else if (pick < 90) begin
            it.action = ACT_FLUSH;
        end else begin
            it.action      = action_t'(2'($urandom_range(0, 3)));
            it.is_new      = 1'($urandom_range(0, 1));
            it.filter_pass = 1'($urandom_range(0, 1));
            it.now_time    = wide[TIME_W-1:0];
        end
        return it;
    endfunction

    // Ignored items do not count toward the phase length. Now and then the
    // sender pauses until every awaited result has come back.
    task automatic run_random(input int n);
        in_item_t item;
        int       done;
        done = 0;
        while (done < n) begin
            item = random_item();
            send_item(item);
            if (item.action != ACT_UNKNOWN) done++;
            if ($urandom_range(0, 99) < 3) begin
                idle_input();
                wait_drained();
            end
        end
    endtask

    // Directed items: field extremes, every action, zero delay, saturated
    // send time, ties, timer asked only once, index past a reduced count,
    // a count of zero, empty-queue ticks and flushes and the unknown action.
    task automatic run_directed();
        // Reset table: one entry of zero delay, so everything passes.
        send_item(make_item(ACT_ARRIVE, 16'h0000, 1'b1, 1'b1, '0));
        send_item(make_item(ACT_ARRIVE, 16'hFFFF, 1'b0, 1'b1, TIME_MAX));
        send_item(make_item(ACT_ARRIVE, 16'h1234, 1'b1, 1'b0, 48'h5A5A_5A5A_5A5A));
        send_item(make_item(ACT_TICK, 16'hFFFF, 1'b1, 1'b1, '0));
        send_item(make_item(ACT_FLUSH, 16'h0000, 1'b0, 1'b0, TIME_MAX));
        send_item(make_item(ACT_UNKNOWN, 16'hBEEF, 1'b1, 1'b1, TIME_MAX));

        quiesce();
        write_reg(REG_DELAY_COUNT, 24'd3);
        write_reg(REG_DELAY_ZERO, 24'd100);
        write_reg(REG_DELAY_ONE, 24'd0);
        write_reg(REG_DELAY_TWO, 24'hFFFFFF);
        write_reg(REG_DELAY_THREE, 24'd50);
        send_item(make_item(ACT_ARRIVE, 16'd1, 1'b1, 1'b1, 48'd1000));
        send_item(make_item(ACT_ARRIVE, 16'd2, 1'b1, 1'b1, 48'd1000));
        send_item(make_item(ACT_ARRIVE, 16'd3, 1'b1, 1'b1, TIME_MAX - 48'd10));
        send_item(make_item(ACT_ARRIVE, 16'd4, 1'b1, 1'b1, 48'd1000));
        // Head not due: one timer request, then silence for the same head.
        send_item(make_item(ACT_TICK, '0, 1'b0, 1'b0, 48'd1050));
        send_item(make_item(ACT_TICK, '0, 1'b0, 1'b0, 48'd1060));
        // Both 1100 entries leave in arrival order, then a timer for the
        // saturated one.
        send_item(make_item(ACT_TICK, '0, 1'b0, 1'b0, 48'd1100));
        send_item(make_item(ACT_ARRIVE, 16'd5, 1'b1, 1'b1, '0));

        // The index now sits at two, past the new count of two.
        quiesce();
        write_reg(REG_DELAY_COUNT, 24'd2);
        send_item(make_item(ACT_ARRIVE, 16'd6, 1'b1, 1'b1, 48'd5));
        send_item(make_item(ACT_ARRIVE, 16'd7, 1'b1, 1'b1, 48'd5));
        send_item(make_item(ACT_FLUSH, '0, 1'b0, 1'b0, '0));

        // A count of zero behaves as one.
        quiesce();
        write_reg(REG_DELAY_COUNT, 24'd0);
        write_reg(REG_DELAY_ZERO, 24'd1);
        send_item(make_item(ACT_ARRIVE, 16'hAAAA, 1'b1, 1'b1, '0));
        send_item(make_item(ACT_ARRIVE, 16'h5555, 1'b1, 1'b1, '0));
        send_item(make_item(ACT_TICK, '0, 1'b0, 1'b0, '0));
        send_item(make_item(ACT_TICK, '0, 1'b0, 1'b0, 48'd1));
    endtask

    // The receiver holds off while arrivals keep coming: the queue fills,
    // later arrivals are dropped, the output register fills and the input
    // stalls. A flush then gives the largest number of results for one item.
    task automatic run_pressure();
        send_item(make_item(ACT_FLUSH, '0, 1'b0, 1'b0, '0));
        quiesce();
        write_reg(REG_DELAY_COUNT, 24'd1);
        write_reg(REG_DELAY_ZERO, 24'hFFFFFF);
        tx_idle_pct  = 0;
        hold_request = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH + 4; i++)
            send_item(make_item(ACT_ARRIVE, HANDLE_W'($urandom_range(0, 65535)),
                                1'b1, 1'b1, sim_now));
        for (int i = 0; i < 4; i++)
            send_item(make_item(ACT_ARRIVE, HANDLE_W'($urandom_range(0, 65535)),
                                1'b0, 1'b1, sim_now));
        send_item(make_item(ACT_FLUSH, '0, 1'b0, 1'b0, sim_now));
        idle_input();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        tracker      = new();
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        hold_request = 1'b0;
        quiet_cycles = 0;
        tx_idle_pct  = 34;
        rx_idle_pct  = 81;
        sim_now      = TIME_W'($urandom());

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Sender idles lightly, receiver heavily.
        run_directed();
        configure(CFG_W'($urandom_range(0, 7)));
        run_random(50);

        // The other way round, with a count above the table size.
        tx_idle_pct = 81;
        rx_idle_pct = 34;
        configure(24'd7);
        run_random(50);
        run_pressure();

        // No idling at all, every table entry in use.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure(24'd4);
        run_random(50);

        idle_input();
        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        tracker.finish_check();
        if (tracker.error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
